// ===== sv/aes_pkg.sv =====
// Package for the AES-128 pipeline: pipeline types, substitution tables,
// round constants and the byte-level round functions. No dependencies.
package aes_pkg;

	localparam int unsigned NR = 10;

	typedef logic [127:0] blk_t;

	typedef enum logic {
		KIND_ENC = 1'b0,
		KIND_DEC = 1'b1
	} kind_t;

	typedef enum logic {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		kind_t kind;
		blk_t  st;
	} stage_t;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] REV_BOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [NR] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [7:0] xt(logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic blk_t sub_bytes(blk_t s, logic inv);
		blk_t o;
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = inv ? REV_BOX[s[127-8*i -: 8]] : FWD_BOX[s[127-8*i -: 8]];
		end
		return o;
	endfunction

	function automatic blk_t shift_rows(blk_t s, logic inv);
		blk_t o;
		int   src;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				src = inv ? (((c + 3 * r) & 3) * 4 + r) : (((c + r) & 3) * 4 + r);
				o[127-8*(c*4+r) -: 8] = s[127-8*src -: 8];
			end
		end
		return o;
	endfunction

	function automatic blk_t mix_cols(blk_t s, logic inv);
		blk_t       o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = s[127-8*(c*4+k) -: 8];
				x2[k] = xt(a[k]);
				x4[k] = xt(x2[k]);
				x8[k] = xt(x4[k]);
			end
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					o[127-8*(c*4+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r])
						^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
						^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
						^ (x8[(r+3)&3] ^ a[(r+3)&3]);
				end else begin
					o[127-8*(c*4+r) -: 8] = x2[r] ^ (x2[(r+1)&3] ^ a[(r+1)&3])
						^ a[(r+2)&3] ^ a[(r+3)&3];
				end
			end
		end
		return o;
	endfunction

endpackage

// ===== sv/aes_if.sv =====
// Valid/ready channel interfaces for the block input and the result output.
// Depends on nothing.
interface aes_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, kind, block_high, block_low, input ready);
	modport sink (input valid, kind, block_high, block_low, output ready);
endinterface

interface aes_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== sv/aes128_block_cipher.sv =====
// Top level of the AES-128 engine: key schedule, input stage and ten round stages.
// Depends on aes_pkg, aes_if, aes_key and aes_round.
//
// The engine accepts one block per cycle when not held and returns it, in order,
// through the input stage and ten round stage registers; the whole pipeline
// advances together and holds while a result waits. After reset and after every key
// write the sequential key schedule fills one round key per cycle; no block is accepted meanwhile.
module aes128_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data,
	aes_in_if.sink      in_ch,
	aes_out_if.source   out_ch
);
	aes_pkg::blk_t   rk [aes_pkg::NR+1];
	logic            key_ok;
	logic            en;
	logic            vld_s [aes_pkg::NR+1];
	aes_pkg::stage_t stg_s [aes_pkg::NR+1];
	aes_pkg::blk_t   blk;

	aes_key u_key (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .rk(rk), .key_ok(key_ok)
	);

	assign en          = !vld_s[aes_pkg::NR] || out_ch.ready;
	assign in_ch.ready = en && key_ok;
	assign blk         = {in_ch.block_high, in_ch.block_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_ch.valid && key_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0].kind <= aes_pkg::kind_t'(in_ch.kind);
			stg_s[0].st   <= blk ^ (in_ch.kind ? rk[aes_pkg::NR] : rk[0]);
		end
	end

	for (genvar j = 1; j <= aes_pkg::NR; j++) begin : g_rnd
		aes_round #(.ROUND(j)) u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_s[j-1]), .stg_in(stg_s[j-1]),
			.rk_enc(rk[j]), .rk_dec(rk[aes_pkg::NR-j]),
			.vld_s(vld_s[j]), .stg_s(stg_s[j])
		);
	end

	assign out_ch.valid       = vld_s[aes_pkg::NR];
	assign out_ch.result_high = stg_s[aes_pkg::NR].st[127:64];
	assign out_ch.result_low  = stg_s[aes_pkg::NR].st[63:0];
endmodule

// ===== sv/aes_key.sv =====
// Key registers and the sequential key schedule that fills the 11 round keys.
// Depends on aes_pkg.
module aes_key (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [63:0]           cfg_data,
	output aes_pkg::blk_t         rk [aes_pkg::NR+1],
	output logic                  key_ok
);
	logic [63:0]   key_hi_q, key_lo_q;
	logic          busy_q;
	logic [3:0]    cnt_q;
	aes_pkg::blk_t rk_q [aes_pkg::NR+1];
	aes_pkg::blk_t prev, nxt;
	logic [31:0]   t;
	logic [31:0]   w4, w5, w6, w7;

	always_comb begin
		prev = rk_q[cnt_q - 4'd1];
		t = {aes_pkg::FWD_BOX[prev[23:16]] ^ aes_pkg::RCON[cnt_q - 4'd1],
			aes_pkg::FWD_BOX[prev[15:8]], aes_pkg::FWD_BOX[prev[7:0]],
			aes_pkg::FWD_BOX[prev[31:24]]};
		w4 = prev[127:96] ^ t;
		w5 = prev[95:64] ^ w4;
		w6 = prev[63:32] ^ w5;
		w7 = prev[31:0] ^ w6;
		nxt = {w4, w5, w6, w7};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			busy_q   <= 1'b1;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == aes_pkg::REG_KEY_HIGH) begin
				key_hi_q <= cfg_data;
			end else begin
				key_lo_q <= cfg_data;
			end
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 4'(aes_pkg::NR)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_we) begin
			if (cnt_q == 4'd0) begin
				rk_q[0] <= {key_hi_q, key_lo_q};
			end else begin
				rk_q[cnt_q] <= nxt;
			end
		end
	end

	assign rk     = rk_q;
	assign key_ok = !busy_q;
endmodule

// ===== sv/aes_round.sv =====
// One pipelined cipher round for both directions, with its stage register.
// Depends on aes_pkg.
module aes_round #(
	parameter int unsigned ROUND = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  aes_pkg::stage_t stg_in,
	input  aes_pkg::blk_t   rk_enc,
	input  aes_pkg::blk_t   rk_dec,
	output logic            vld_s,
	output aes_pkg::stage_t stg_s
);
	localparam bit LAST = (ROUND == aes_pkg::NR);

	aes_pkg::blk_t t;

	always_comb begin
		if (stg_in.kind == aes_pkg::KIND_ENC) begin
			t = aes_pkg::sub_bytes(aes_pkg::shift_rows(stg_in.st, 1'b0), 1'b0);
			if (!LAST) begin
				t = aes_pkg::mix_cols(t, 1'b0);
			end
			t = t ^ rk_enc;
		end else begin
			t = aes_pkg::sub_bytes(aes_pkg::shift_rows(stg_in.st, 1'b1), 1'b1) ^ rk_dec;
			if (!LAST) begin
				t = aes_pkg::mix_cols(t, 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s <= '{kind: stg_in.kind, st: t};
		end
	end
endmodule

// ===== sv/aes_chk.sv =====
// Port-level checker for aes128_block_cipher and the bind that attaches it.
// Depends on aes128_block_cipher.
module aes_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_high,
	input logic [63:0] result_low
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("A waiting result beat was dropped.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_high) && $stable(result_low))
		else $error("A waiting result beat changed.");

	a_key_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("Input accepted right after a key write.");

	a_key_long: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> ##10 !in_ready)
		else $error("Input accepted before the key schedule finished.");
endmodule

bind aes128_block_cipher aes_chk u_chk (
	.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.result_high(out_ch.result_high), .result_low(out_ch.result_low)
);

// ===== sim/tb_aes128_block_cipher.sv =====
// Self-checking testbench for the AES-128 engine: directed and random blocks,
// key changes between phases, random idling and long output stalls.
// Depends on aes_pkg, aes_if and aes128_block_cipher.
`timescale 1ns / 100ps

module tb_aes128_block_cipher;

	typedef struct {
		aes_pkg::kind_t kind;
		logic [63:0]    hi;
		logic [63:0]    lo;
	} blk_item_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [63:0] cfg_data;

	aes_in_if  in_ch ();
	aes_out_if out_ch ();

	aes128_block_cipher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	blk_item_t   pending_blocks[$];
	cipher_out_t expected_blocks[$];
	logic [63:0] cur_key_hi, cur_key_lo;
	int          send_idle_pct, recv_stall_pct;
	int          hold_off_cycles;
	int          error_count;

	logic [7:0] sbox [256];
	logic [7:0] inv_sbox [256];

	function automatic logic [7:0] gf_dbl(logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] v, logic [7:0] m);
		logic [7:0] acc;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (m[k])
				acc ^= v;
			v = gf_dbl(v);
		end
		return acc;
	endfunction

	// Encrypts or decrypts one block with the key currently written.
	function automatic cipher_out_t aes_cipher(blk_item_t it);
		logic [7:0] w [176];
		logic [7:0] s [16];
		logic [7:0] o [16];
		logic [7:0] t [4];
		logic [7:0] x;
		logic [7:0] rc;
		logic [7:0] mrow [4];
		cipher_out_t res;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) begin
			w[i]     = cur_key_hi[63-8*i -: 8];
			w[8+i]   = cur_key_lo[63-8*i -: 8];
			s[i]     = it.hi[63-8*i -: 8];
			s[8+i]   = it.lo[63-8*i -: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++)
				t[j] = w[(i-1)*4+j];
			if ((i & 3) == 0) begin
				x    = t[0];
				t[0] = sbox[t[1]] ^ rc;
				t[1] = sbox[t[2]];
				t[2] = sbox[t[3]];
				t[3] = sbox[x];
				rc   = gf_dbl(rc);
			end
			for (int j = 0; j < 4; j++)
				w[i*4+j] = w[(i-4)*4+j] ^ t[j];
		end
		if (it.kind == aes_pkg::KIND_ENC) begin
			mrow = '{8'h02, 8'h03, 8'h01, 8'h01};
			for (int k = 0; k < 16; k++) s[k] ^= w[k];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int q = 0; q < 4; q++)
						o[c*4+q] = sbox[s[((c+q)&3)*4+q]];
				if (r != 10) begin
					for (int c = 0; c < 4; c++)
						for (int q = 0; q < 4; q++)
							s[c*4+q] = gf_mul(o[c*4], mrow[(4-q)&3])
								^ gf_mul(o[c*4+1], mrow[(5-q)&3])
								^ gf_mul(o[c*4+2], mrow[(6-q)&3])
								^ gf_mul(o[c*4+3], mrow[(7-q)&3]);
				end else
					s = o;
				for (int k = 0; k < 16; k++) s[k] ^= w[r*16+k];
			end
		end else begin
			mrow = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
			for (int k = 0; k < 16; k++) s[k] ^= w[160+k];
			for (int r = 9; r >= 0; r--) begin
				for (int c = 0; c < 4; c++)
					for (int q = 0; q < 4; q++)
						o[c*4+q] = inv_sbox[s[((c+3*q)&3)*4+q]] ^ w[r*16+c*4+q];
				if (r != 0) begin
					for (int c = 0; c < 4; c++)
						for (int q = 0; q < 4; q++)
							s[c*4+q] = gf_mul(o[c*4], mrow[(4-q)&3])
								^ gf_mul(o[c*4+1], mrow[(5-q)&3])
								^ gf_mul(o[c*4+2], mrow[(6-q)&3])
								^ gf_mul(o[c*4+3], mrow[(7-q)&3]);
				end else
					s = o;
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.hi[63-8*i -: 8] = s[i];
			res.lo[63-8*i -: 8] = s[8+i];
		end
		return res;
	endfunction

	// The S-box is built from the field inverse and the affine map.
	initial begin
		logic [7:0] inv, b;
		for (int v = 0; v < 256; v++) begin
			inv = 8'h00;
			for (int u = 1; u < 256; u++)
				if (gf_mul(v[7:0], u[7:0]) == 8'h01)
					inv = u[7:0];
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sbox[v]     = b;
			inv_sbox[b] = v[7:0];
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offers queued blocks, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_blocks.push_back(aes_cipher(pending_blocks.pop_front()));
			end
			if ((!in_ch.valid || in_ch.ready)) begin
				if (pending_blocks.size() > 0
						&& $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid      <= 1'b1;
					in_ch.kind       <= pending_blocks[0].kind;
					in_ch.block_high <= pending_blocks[0].hi;
					in_ch.block_low  <= pending_blocks[0].lo;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: unexpected result %h %h", $time,
						out_ch.result_high, out_ch.result_low);
					error_count++;
				end else begin
					cipher_out_t e;
					e = expected_blocks.pop_front();
					if (e.hi !== out_ch.result_high) begin
						$display("%0t: result_high expected %h actual %h", $time,
							e.hi, out_ch.result_high);
						error_count++;
					end
					if (e.lo !== out_ch.result_low) begin
						$display("%0t: result_low expected %h actual %h", $time,
							e.lo, out_ch.result_low);
						error_count++;
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic queue_block(aes_pkg::kind_t k, logic [63:0] hi, logic [63:0] lo);
		blk_item_t it;
		it.kind = k;
		it.hi   = hi;
		it.lo   = lo;
		pending_blocks.push_back(it);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			queue_block($urandom_range(1) ? aes_pkg::KIND_DEC : aes_pkg::KIND_ENC,
				{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic wait_drained();
		while (pending_blocks.size() != 0 || in_ch.valid || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_key(logic [63:0] hi, logic [63:0] lo);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= aes_pkg::REG_KEY_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_idx  <= aes_pkg::REG_KEY_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_key_hi = hi;
		cur_key_lo = lo;
	endtask

	initial begin
		error_count     = 0;
		hold_off_cycles = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		cur_key_hi      = '0;
		cur_key_lo      = '0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = aes_pkg::REG_KEY_HIGH;
		cfg_data        = '0;
		in_ch.valid      = 1'b0;
		in_ch.kind       = aes_pkg::KIND_ENC;
		in_ch.block_high = '0;
		in_ch.block_low  = '0;
		out_ch.ready     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Zero key after reset, then the standard test key and extreme keys.
		queue_block(aes_pkg::KIND_ENC, '0, '0);
		queue_block(aes_pkg::KIND_DEC, '0, '0);
		queue_block(aes_pkg::KIND_ENC, '1, '1);
		queue_block(aes_pkg::KIND_DEC, '1, '1);
		wait_drained();
		write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		queue_block(aes_pkg::KIND_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block(aes_pkg::KIND_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		queue_block(aes_pkg::KIND_ENC, 64'h8000000000000000, 64'h0000000000000001);
		queue_block(aes_pkg::KIND_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		wait_drained();
		write_key('1, '1);
		queue_block(aes_pkg::KIND_ENC, '0, '1);
		queue_block(aes_pkg::KIND_DEC, '1, '0);
		queue_random(6);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 15) : 0;
			recv_stall_pct = (ph == 2) ? 84 : (ph == 3 ? 15 : 0);
			if (ph == 1)
				write_key('0, '1);
			else
				write_key({$urandom, $urandom}, {$urandom, $urandom});
			queue_random(150);
			if (ph == 0)
				hold_off_cycles = 200;
			wait_drained();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 150;
		queue_random(30);
		wait_drained();
		if (error_count == 0)
			$display("tb_aes128_block_cipher: clean");
		else
			$display("tb_aes128_block_cipher: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_aes128_block_cipher: errors");
		$finish;
	end

endmodule
